/* hw/rtl/dom_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_pkg
// Shared types, codes and reset values for the damped orbit motion
// integrator: field widths, item kinds, register indexes, datapath
// operations and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package dom_pkg;

  // Field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned FRAC_W     = 18;
  localparam int unsigned ANG_W      = 32;
  localparam int unsigned DIST_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Longest time step taken by an inertia item, Q0.16 seconds
  localparam int unsigned MAX_DT = 6554;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_INERTIA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RATES   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW_RT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PIT_RT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_RT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PITCH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PITCH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_THR  = 3'd7;

  // Configuration register set
  typedef struct packed {
    logic [23:0] damping;       // Q8.16 per second
    logic [30:0] max_yaw_rate;  // Q3.28
    logic [30:0] max_pit_rate;  // Q3.28
    logic [46:0] max_dist_rate; // Q31.16
    logic [31:0] min_pitch;     // signed Q3.28
    logic [31:0] max_pitch;     // signed Q3.28
    logic [46:0] min_dist;      // Q31.16
    logic [30:0] settle_thr;    // Q3.28
  } cfg_t;

  // Reset values: one, one rad/s angular bounds, +-pi/2 pitch, one metre floor
  localparam cfg_t CFG_RST = '{
    damping:       24'd65536,
    max_yaw_rate:  31'd268435456,
    max_pit_rate:  31'd268435456,
    max_dist_rate: 47'd65536000,
    min_pitch:     32'hE6DE_04AC,
    max_pitch:     32'h1921_FB54,
    min_dist:      47'd65536,
    settle_thr:    31'd268435
  };

  // Datapath operations run through the shared multiplier
  typedef enum logic [3:0] {
    OP_DECAY_YAW,
    OP_DECAY_PITCH,
    OP_DECAY_DIST,
    OP_MOVE_YAW,
    OP_MOVE_PITCH,
    OP_MOVE_DIST,
    OP_BLEND_YAW,
    OP_BLEND_PITCH,
    OP_BLEND_DIST
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic       accept;    // latch the input item
    logic       prod_en;   // damping times time step
    logic       fact_en;   // decay factor
    logic       load_en;   // operand magnitude and multiplier setup
    logic       mul_en;    // one 16-bit digit of the product
    logic       fin_en;    // scale and sign the product
    logic       wb_en;     // write the result into the pose or rates
    logic       pin_en;    // pin the pose to the target
    logic       rates_en;  // load the rates
    logic       settle_en; // recompute settled
    logic       out_load;  // copy state into the result register
    op_e        op;
    logic [1:0] dig;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pin;
  } status_t;

endpackage

/* hw/rtl/dom_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_in_if
// Input item channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface dom_in_if;
  import dom_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [DT_W-1:0]          time_step;
  logic [FRAC_W-1:0]        blend_fraction;
  logic signed [ANG_W-1:0]  yaw_value;
  logic signed [ANG_W-1:0]  pitch_value;
  logic signed [DIST_W-1:0] dist_value;

  modport source (
    output valid, kind, time_step, blend_fraction, yaw_value, pitch_value, dist_value,
    input  ready
  );

  modport sink (
    input  valid, kind, time_step, blend_fraction, yaw_value, pitch_value, dist_value,
    output ready
  );
endinterface

/* hw/rtl/dom_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_out_if
// Result item channel: valid/ready handshake with pose, rates and settled.
// ----------------------------------------------------------------------------
interface dom_out_if;
  import dom_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ANG_W-1:0]  yaw_out;
  logic signed [ANG_W-1:0]  pitch_out;
  logic signed [DIST_W-1:0] distance_out;
  logic signed [ANG_W-1:0]  yaw_rate_out;
  logic signed [ANG_W-1:0]  pitch_rate_out;
  logic signed [DIST_W-1:0] dist_rate_out;
  logic                     settled_out;

  modport source (
    output valid, yaw_out, pitch_out, distance_out, yaw_rate_out, pitch_rate_out,
           dist_rate_out, settled_out,
    input  ready
  );

  modport sink (
    input  valid, yaw_out, pitch_out, distance_out, yaw_rate_out, pitch_rate_out,
           dist_rate_out, settled_out,
    output ready
  );
endinterface

/* hw/rtl/dom_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
interface dom_cfg_if;
  import dom_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* hw/rtl/dom_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_ctrl
// Sequencer: takes one item at a time, walks the datapath through the
// operations of its kind and hands the result to the output register.
// ----------------------------------------------------------------------------
module dom_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dom_pkg::status_t  status_i,
  output dom_pkg::cmd_t     cmd_o
);
  import dom_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FACT,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_WB,
    ST_PIN,
    ST_RATES,
    ST_SETTLE,
    ST_OUT
  } state_e;

  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic [1:0] dig_q, dig_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Operation that follows in the same item
  function automatic op_e next_op(input op_e op);
    op_e n;
    case (op)
      OP_DECAY_YAW:   n = OP_DECAY_PITCH;
      OP_DECAY_PITCH: n = OP_DECAY_DIST;
      OP_DECAY_DIST:  n = OP_MOVE_YAW;
      OP_MOVE_YAW:    n = OP_MOVE_PITCH;
      OP_MOVE_PITCH:  n = OP_MOVE_DIST;
      OP_BLEND_YAW:   n = OP_BLEND_PITCH;
      OP_BLEND_PITCH: n = OP_BLEND_DIST;
      default:        n = op;
    endcase
    return n;
  endfunction

  // Distance operands need three digits, angles two
  function automatic logic [1:0] top_digit(input op_e op);
    logic [1:0] d;
    case (op)
      OP_DECAY_DIST, OP_MOVE_DIST, OP_BLEND_DIST: d = 2'd2;
      default:                                    d = 2'd1;
    endcase
    return d;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.dig   = dig_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.prod_en = 1'b1;
        case (status_i.kind)
          KIND_INERTIA: state_d = ST_FACT;
          KIND_FLY: begin
            if (status_i.pin) begin
              state_d = ST_PIN;
            end else begin
              op_d    = OP_BLEND_YAW;
              state_d = ST_LOAD;
            end
          end
          KIND_RATES: state_d = ST_RATES;
          default:    state_d = ST_OUT;
        endcase
      end
      ST_FACT: begin
        cmd_o.fact_en = 1'b1;
        op_d          = OP_DECAY_YAW;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_en = 1'b1;
        dig_d         = top_digit(op_q);
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (dig_q == 2'd0) begin
          state_d = ST_FIN;
        end else begin
          dig_d = dig_q - 2'd1;
        end
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d      = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb_en = 1'b1;
        if (op_q == OP_MOVE_DIST) begin
          state_d = ST_SETTLE;
        end else if (op_q == OP_BLEND_DIST) begin
          state_d = ST_OUT;
        end else begin
          op_d    = next_op(op_q);
          state_d = ST_LOAD;
        end
      end
      ST_PIN: begin
        cmd_o.pin_en = 1'b1;
        state_d      = ST_OUT;
      end
      ST_RATES: begin
        cmd_o.rates_en = 1'b1;
        state_d        = ST_OUT;
      end
      ST_SETTLE: begin
        cmd_o.settle_en = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DECAY_YAW;
      dig_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/dom_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_dpath
// Pose and rate registers, decay factor, a shared 16 x 33 digit-serial
// multiplier and the write-back logic with saturation and limits.
// ----------------------------------------------------------------------------
module dom_dpath #(
  parameter int unsigned MaxDt = dom_pkg::MAX_DT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dom_pkg::cmd_t     cmd_i,
  output dom_pkg::status_t  status_o,
  input  dom_pkg::cfg_t     cfg_i,
  input  logic [1:0]        kind_i,
  input  logic [15:0]       time_step_i,
  input  logic [17:0]       blend_fraction_i,
  input  logic signed [31:0] yaw_value_i,
  input  logic signed [31:0] pitch_value_i,
  input  logic signed [47:0] dist_value_i,
  output logic [31:0]       yaw_out_o,
  output logic [31:0]       pitch_out_o,
  output logic [47:0]       distance_out_o,
  output logic [31:0]       yaw_rate_out_o,
  output logic [31:0]       pitch_rate_out_o,
  output logic [47:0]       dist_rate_out_o,
  output logic              settled_out_o
);
  import dom_pkg::*;

  localparam logic [15:0] MaxDtW = 16'(MaxDt);
  localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

  // Latched item
  logic [1:0]  kind_q;
  logic [15:0] h_q;
  logic [17:0] t_q;
  logic [31:0] ty_q, tp_q;
  logic [47:0] td_q;

  // Pose, rates and settled
  logic [31:0] yaw_q, yaw_d, pitch_q, pitch_d, yr_q, yr_d, pr_q, pr_d;
  logic [47:0] dist_q, dist_d, dr_q, dr_d;
  logic        settled_q, settled_d;

  // Decay factor and multiplier
  logic [39:0] prod_q, prod_d;
  logic [32:0] factor_q, factor_d;
  logic [48:0] src;
  logic [47:0] mag_q;
  logic        neg_q;
  logic [32:0] fsel_q, fsel_d;
  logic        sh32_q, sh32_d;
  logic [15:0] digit;
  logic [48:0] pp;
  logic [80:0] acc_q, acc_d;
  logic [47:0] magr;
  logic [48:0] res_q, res_d;

  // Write-back candidates
  logic [48:0] cl_yr, cl_pr, cl_dr;
  logic [49:0] sum_y, sum_p, sum_d;
  logic [31:0] new_y, new_p, pin_p;
  logic [47:0] new_d, flo_d, pin_d;
  logic [31:0] ymag, pmag;
  logic [47:0] dmag;
  logic        settle_now;

  // Saturate a wide sum to 32 bits
  function automatic logic [31:0] sat32(input logic [49:0] v);
    logic [31:0] r;
    if ((&v[49:31]) || !(|v[49:31])) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Saturate a wide sum to 48 bits
  function automatic logic [47:0] sat48(input logic [49:0] v);
    logic [47:0] r;
    if ((&v[49:47]) || !(|v[49:47])) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = 48'h7FFF_FFFF_FFFF;
    end
    return r;
  endfunction

  // Limit pitch to the high bound first, then raise to the low bound
  function automatic logic [31:0] clamp_pitch(input logic [31:0] p,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi);
    logic [31:0] r;
    r = p;
    if ($signed(r) > $signed(hi)) r = hi;
    if ($signed(r) < $signed(lo)) r = lo;
    return r;
  endfunction

  // Raise distance to the floor
  function automatic logic [47:0] floor_dist(input logic [47:0] d, input logic [46:0] lo);
    logic [47:0] r;
    r = d;
    if ($signed(d) < $signed({1'b0, lo})) r = {1'b0, lo};
    return r;
  endfunction

  // Limit a signed value to +-bound
  function automatic logic [48:0] clamp_abs(input logic [48:0] v, input logic [46:0] b);
    logic [48:0] bs, nb, r;
    bs = {2'b00, b};
    nb = 49'd0 - bs;
    if ($signed(v) > $signed(bs)) begin
      r = bs;
    end else if ($signed(v) < $signed(nb)) begin
      r = nb;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign status_o.kind = kind_q;
  assign status_o.pin  = |t_q[17:16];

  // Latch the item, clamping the time step
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      h_q    <= (time_step_i > MaxDtW) ? MaxDtW : time_step_i;
      t_q    <= blend_fraction_i;
      ty_q   <= yaw_value_i;
      tp_q   <= pitch_value_i;
      td_q   <= dist_value_i;
    end
  end

  // Decay factor: 1 - damping*dt in Q1.32, floored at zero
  assign prod_d   = cfg_i.damping * h_q;
  assign factor_d = (|prod_q[39:32]) ? 33'd0 : OneQ32 - {1'b0, prod_q[31:0]};

  // Operand of the current operation
  always_comb begin
    case (cmd_i.op)
      OP_DECAY_YAW, OP_MOVE_YAW:     src = {{17{yr_q[31]}}, yr_q};
      OP_DECAY_PITCH, OP_MOVE_PITCH: src = {{17{pr_q[31]}}, pr_q};
      OP_DECAY_DIST, OP_MOVE_DIST:   src = {dr_q[47], dr_q};
      OP_BLEND_YAW:   src = {{17{ty_q[31]}}, ty_q} - {{17{yaw_q[31]}}, yaw_q};
      OP_BLEND_PITCH: src = {{17{tp_q[31]}}, tp_q} - {{17{pitch_q[31]}}, pitch_q};
      OP_BLEND_DIST:  src = {td_q[47], td_q} - {dist_q[47], dist_q};
      default:        src = 49'd0;
    endcase
  end

  // Multiplier factor and scaling
  always_comb begin
    case (cmd_i.op)
      OP_DECAY_YAW, OP_DECAY_PITCH, OP_DECAY_DIST: begin
        fsel_d = factor_q;
        sh32_d = 1'b1;
      end
      OP_MOVE_YAW, OP_MOVE_PITCH, OP_MOVE_DIST: begin
        fsel_d = {17'd0, h_q};
        sh32_d = 1'b0;
      end
      default: begin
        fsel_d = {15'd0, t_q};
        sh32_d = 1'b0;
      end
    endcase
  end

  // One digit of the magnitude per cycle, most significant first
  always_comb begin
    case (cmd_i.dig)
      2'd0:    digit = mag_q[15:0];
      2'd1:    digit = mag_q[31:16];
      default: digit = mag_q[47:32];
    endcase
  end

  assign pp    = digit * fsel_q;
  assign acc_d = {acc_q[64:0], 16'd0} + {32'd0, pp};

  // Drop the fraction bits, truncating the magnitude, then restore the sign
  assign magr  = sh32_q ? acc_q[79:32] : acc_q[63:16];
  assign res_d = neg_q ? (49'd0 - {1'b0, magr}) : {1'b0, magr};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) prod_q <= prod_d;
    if (cmd_i.fact_en) factor_q <= factor_d;
    if (cmd_i.load_en) begin
      mag_q  <= src[48] ? 48'(49'd0 - src) : src[47:0];
      neg_q  <= src[48];
      fsel_q <= fsel_d;
      sh32_q <= sh32_d;
      acc_q  <= 81'd0;
    end else if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.fin_en) res_q <= res_d;
  end

  // Write-back candidates
  assign cl_yr = clamp_abs(res_q, {16'd0, cfg_i.max_yaw_rate});
  assign cl_pr = clamp_abs(res_q, {16'd0, cfg_i.max_pit_rate});
  assign cl_dr = clamp_abs(res_q, cfg_i.max_dist_rate);
  assign sum_y = {{18{yaw_q[31]}}, yaw_q} + {res_q[48], res_q};
  assign sum_p = {{18{pitch_q[31]}}, pitch_q} + {res_q[48], res_q};
  assign sum_d = {{2{dist_q[47]}}, dist_q} + {res_q[48], res_q};
  assign new_y = sat32(sum_y);
  assign new_p = clamp_pitch(sat32(sum_p), cfg_i.min_pitch, cfg_i.max_pitch);
  assign new_d = sat48(sum_d);
  assign flo_d = floor_dist(new_d, cfg_i.min_dist);
  assign pin_p = clamp_pitch(tp_q, cfg_i.min_pitch, cfg_i.max_pitch);
  assign pin_d = floor_dist(td_q, cfg_i.min_dist);

  // Settle test on the rate magnitudes; distance rate scaled to Q3.28
  assign ymag       = yr_q[31] ? (32'd0 - yr_q) : yr_q;
  assign pmag       = pr_q[31] ? (32'd0 - pr_q) : pr_q;
  assign dmag       = dr_q[47] ? (48'd0 - dr_q) : dr_q;
  assign settle_now = (ymag < {1'b0, cfg_i.settle_thr}) &&
                      (pmag < {1'b0, cfg_i.settle_thr}) &&
                      ({dmag, 12'd0} < {29'd0, cfg_i.settle_thr});

  // Next pose, rates and settled
  always_comb begin
    yaw_d     = yaw_q;
    pitch_d   = pitch_q;
    dist_d    = dist_q;
    yr_d      = yr_q;
    pr_d      = pr_q;
    dr_d      = dr_q;
    settled_d = settled_q;
    if (cmd_i.wb_en) begin
      case (cmd_i.op)
        OP_DECAY_YAW:   yr_d    = cl_yr[31:0];
        OP_DECAY_PITCH: pr_d    = cl_pr[31:0];
        OP_DECAY_DIST:  dr_d    = cl_dr[47:0];
        OP_MOVE_YAW:    yaw_d   = new_y;
        OP_MOVE_PITCH:  pitch_d = new_p;
        OP_MOVE_DIST:   dist_d  = flo_d;
        OP_BLEND_YAW:   yaw_d   = new_y;
        OP_BLEND_PITCH: pitch_d = new_p;
        OP_BLEND_DIST: begin
          dist_d    = new_d;
          settled_d = 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd_i.pin_en) begin
      yaw_d     = ty_q;
      pitch_d   = pin_p;
      dist_d    = pin_d;
      yr_d      = 32'd0;
      pr_d      = 32'd0;
      dr_d      = 48'd0;
      settled_d = 1'b1;
    end
    if (cmd_i.rates_en) begin
      yr_d = ty_q;
      pr_d = tp_q;
      dr_d = td_q;
    end
    if (cmd_i.settle_en) begin
      settled_d = settle_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q     <= 32'd0;
      pitch_q   <= 32'd0;
      dist_q    <= 48'd0;
      yr_q      <= 32'd0;
      pr_q      <= 32'd0;
      dr_q      <= 48'd0;
      settled_q <= 1'b1;
    end else begin
      yaw_q     <= yaw_d;
      pitch_q   <= pitch_d;
      dist_q    <= dist_d;
      yr_q      <= yr_d;
      pr_q      <= pr_d;
      dr_q      <= dr_d;
      settled_q <= settled_d;
    end
  end

  // Result register: snapshot of the state after the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      yaw_out_o        <= yaw_q;
      pitch_out_o      <= pitch_q;
      distance_out_o   <= dist_q;
      yaw_rate_out_o   <= yr_q;
      pitch_rate_out_o <= pr_q;
      dist_rate_out_o  <= dr_q;
      settled_out_o    <= settled_q;
    end
  end

endmodule

/* hw/rtl/damped_orbit_motion_integrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_orbit_motion_integrator
// Orbit camera motion: inertia steps, fly-to blends and rate loads.
//
// Items arrive on cmd_i (valid/ready) and each gives exactly one result on
// res_o (valid/ready): the pose, the rates and the settled flag after it.
// Registers are written on cfg_i by index; cfg_i is always ready, and the
// user must write it only while no item is in flight; it is not enforced.
// One item is worked at a time through a single 16 x 33 multiplier that
// takes one 16-bit digit of its operand per cycle. An inertia item takes
// six products, a partial fly-to three; a pinning fly-to, a rate load and
// an unused kind take none. cmd_i is ready again the cycle after the
// result enters the output register.
// The output register holds a finished result while the next item is
// taken and computed; a stall on res_o only delays the following result.
// Reset clears the pose and rates, sets settled and loads the register
// defaults; no item is pending afterwards.
// ----------------------------------------------------------------------------
module damped_orbit_motion_integrator #(
  parameter int unsigned MaxDt = dom_pkg::MAX_DT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dom_in_if.sink    cmd_i,
  dom_out_if.source res_o,
  dom_cfg_if.sink   cfg_i
);
  import dom_pkg::*;

  cmd_t    cmd;
  status_t status;
  cfg_t    cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DAMPING:     cfg_d.damping       = cfg_i.data[23:0];
        REG_MAX_YAW_RT:  cfg_d.max_yaw_rate  = cfg_i.data[30:0];
        REG_MAX_PIT_RT:  cfg_d.max_pit_rate  = cfg_i.data[30:0];
        REG_MAX_DIST_RT: cfg_d.max_dist_rate = cfg_i.data[46:0];
        REG_MIN_PITCH:   cfg_d.min_pitch     = cfg_i.data[31:0];
        REG_MAX_PITCH:   cfg_d.max_pitch     = cfg_i.data[31:0];
        REG_MIN_DIST:    cfg_d.min_dist      = cfg_i.data[46:0];
        REG_SETTLE_THR:  cfg_d.settle_thr    = cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dom_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dom_dpath #(
    .MaxDt (MaxDt)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg_q),
    .kind_i           (cmd_i.kind),
    .time_step_i      (cmd_i.time_step),
    .blend_fraction_i (cmd_i.blend_fraction),
    .yaw_value_i      (cmd_i.yaw_value),
    .pitch_value_i    (cmd_i.pitch_value),
    .dist_value_i     (cmd_i.dist_value),
    .yaw_out_o        (res_o.yaw_out),
    .pitch_out_o      (res_o.pitch_out),
    .distance_out_o   (res_o.distance_out),
    .yaw_rate_out_o   (res_o.yaw_rate_out),
    .pitch_rate_out_o (res_o.pitch_rate_out),
    .dist_rate_out_o  (res_o.dist_rate_out),
    .settled_out_o    (res_o.settled_out)
  );

`ifndef SYNTHESIS
  // The datapath never gets two steps in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.prod_en, cmd.fact_en, cmd.load_en, cmd.mul_en, cmd.fin_en,
              cmd.wb_en, cmd.pin_en, cmd.rates_en, cmd.settle_en, cmd.out_load}))
    else $error("more than one datapath step issued");

  // An accepted item closes the input until its result enters the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !cmd_i.ready)
    else $error("input still open after acceptance");

  // A result only enters the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!res_o.valid || res_o.ready))
    else $error("pending result overwritten");
`endif

endmodule
